// ===== src/ish_pkg.sv =====
package ish_pkg;

  localparam int unsigned CMD_W        = 2;
  localparam int unsigned VAL_W        = 14;
  localparam int unsigned BIN_IDX_W    = 7;
  localparam int unsigned COUNT_W      = 15;
  localparam int unsigned SPREAD_W     = 8;
  localparam int unsigned CFG_W        = 8;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned OUT_TDATA_W  = 40;
  localparam int unsigned PADDR_W      = 3;

  localparam int unsigned MAX_DIST_RST = 100;
  localparam logic [COUNT_W-1:0] BIN_MAX = '1;

  localparam logic [0:0] REG_MAX_DIST = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAIR,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_e;

endpackage

// ===== src/interleaver_spread_histogram.sv =====
// Interleaver spread histogram. Each transfer on the slave stream carries one command (clear,
// push a permutation entry, read one histogram bin, or no operation) and yields exactly one
// result transfer with the bin count, the current spread and the number of entries seen. The
// pair counts live in a single-port-write, registered-read memory of 2^(2*ceil(log2 MAX_DIST))
// bins (16384 at the default), and the recent entries in a circular window memory of MAX_DIST
// words. A push takes one histogram read-modify-write per window entry paired, one per cycle,
// and a push that forms no pair goes straight to completion. A clear sweeps the whole
// histogram memory one bin a cycle; the same sweep runs after reset, during which
// s_axis_tready stays low while APB writes are taken. A finished result waits in the output
// register, so the next command is taken while it is unclaimed.
module interleaver_spread_histogram import ish_pkg::*; #(
  parameter int unsigned MAX_DIST = 128,
  parameter int unsigned MAX_LEN  = 16384
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // command[1:0], entry_value[15:2], bin_in_distance[22:16], bin_out_distance[29:23], zeros
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // bin_count[14:0], spread[22:15], entries_seen[37:23], zeros
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned DW         = $clog2(MAX_DIST);
  localparam int unsigned HAW        = 2 * DW;
  localparam int unsigned HDEPTH     = 1 << HAW;
  localparam int unsigned CW         = $clog2(MAX_LEN + 1);
  localparam int unsigned SPREAD_RST = (MAX_DIST < MAX_DIST_RST) ? MAX_DIST : MAX_DIST_RST;

  state_e st_q, st_d;

  logic [CFG_W-1:0]     cfg_q;
  logic [SPREAD_W-1:0]  spread_q;
  logic [DW-1:0]        fill_q;
  logic [CW-1:0]        cnt_q;
  logic [DW-1:0]        head_q;
  logic [DW-1:0]        rp_q;
  logic [DW-1:0]        k_q;
  logic [DW-1:0]        pairs_q;
  logic [CFG_W-1:0]     md_q;
  logic [VAL_W-1:0]     v_q;
  logic [DW-1:0]        din1_q;
  logic                 s1_q;
  logic                 s2_q;
  logic                 hit2_q;
  logic [HAW-1:0]       hw_addr_q;
  logic [HAW-1:0]       clr_q;
  logic                 pend_q;
  logic                 rng_q;
  logic [COUNT_W-1:0]   res_cnt_q;
  logic                 out_vld_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [VAL_W-1:0]     win_mem [MAX_DIST];
  logic [VAL_W-1:0]     win_rd_q;
  logic [COUNT_W-1:0]   hist_mem [HDEPTH];
  logic [COUNT_W-1:0]   hist_rd_q;

  cmd_e                 cmd;
  logic [VAL_W-1:0]     in_val;
  logic [BIN_IDX_W-1:0] in_row;
  logic [BIN_IDX_W-1:0] in_col;
  logic                 accept;
  logic                 cfg_we;
  logic [CFG_W-1:0]     md_eff;
  logic [CFG_W-1:0]     md_m1;
  logic [DW-1:0]        pairs_d;
  logic [DW-1:0]        head_nxt;
  logic [DW-1:0]        head_prev;
  logic [DW-1:0]        rp_nxt;
  logic [VAL_W-1:0]     dout;
  logic                 hit;
  logic                 spread_upd;
  logic [VAL_W-1:0]     pair_max;
  logic [HAW-1:0]       hist_raddr;
  logic                 hist_we;
  logic [HAW-1:0]       hist_waddr;
  logic [COUNT_W-1:0]   hist_wdata;
  logic                 load_out;
  logic                 in_range;

  assign cmd    = cmd_e'(s_axis_tdata[1:0]);
  assign in_val = s_axis_tdata[15:2];
  assign in_row = s_axis_tdata[22:16];
  assign in_col = s_axis_tdata[29:23];
  assign accept = s_axis_tvalid && s_axis_tready;

  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_MAX_DIST);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_DIST) ? {24'd0, cfg_q} : 32'd0;

  assign md_eff  = (int'(cfg_q) > int'(MAX_DIST)) ? CFG_W'(MAX_DIST) : cfg_q;
  assign md_m1   = (md_eff > 8'd1) ? md_eff - 8'd1 : 8'd0;
  assign pairs_d = (int'(md_m1) < int'(fill_q)) ? DW'(md_m1) : fill_q;

  assign head_nxt  = (head_q == DW'(MAX_DIST - 1)) ? '0 : head_q + 1'b1;
  assign head_prev = (head_q == '0) ? DW'(MAX_DIST - 1) : head_q - 1'b1;
  assign rp_nxt    = (rp_q == '0) ? DW'(MAX_DIST - 1) : rp_q - 1'b1;

  assign in_range = (int'(in_row) < int'(MAX_DIST)) && (int'(in_col) < int'(MAX_DIST));

  assign dout       = (v_q >= win_rd_q) ? v_q - win_rd_q : win_rd_q - v_q;
  assign hit        = dout < VAL_W'(md_q);
  assign spread_upd = s1_q && (VAL_W'(din1_q) <= VAL_W'(spread_q))
                      && (dout <= VAL_W'(spread_q));
  assign pair_max   = (VAL_W'(din1_q) > dout) ? VAL_W'(din1_q) : dout;

  assign hist_raddr = (st_q == ST_IDLE) ? {DW'(in_row), DW'(in_col)}
                                        : {din1_q, DW'(dout)};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          st_d = pend_q ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_CLEAR: st_d = ST_CLEAR;
            CMD_PUSH:  st_d = (pairs_d == '0) ? ST_DONE : ST_PAIR;
            CMD_READ:  st_d = ST_READ;
            CMD_NOP:   st_d = ST_DONE;
            default:   st_d = ST_DONE;
          endcase
        end
      end
      ST_PAIR: begin
        if (k_q + 1'b1 == pairs_q) begin
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!s1_q) begin
          st_d = ST_DONE;
        end
      end
      ST_READ: st_d = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (st_q == ST_IDLE);
    load_out      = (st_q == ST_DONE) && (!out_vld_q || m_axis_tready);
    if (st_q == ST_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_q;
      hist_wdata = '0;
    end else begin
      hist_we    = s2_q && hit2_q && (hist_rd_q != BIN_MAX);
      hist_waddr = hw_addr_q;
      hist_wdata = hist_rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cmd == CMD_PUSH)) begin
      win_mem[head_q] <= in_val;
    end
    win_rd_q <= win_mem[rp_q];
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rd_q <= hist_mem[hist_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLEAR;
      cfg_q     <= CFG_W'(MAX_DIST_RST);
      spread_q  <= SPREAD_W'(SPREAD_RST);
      fill_q    <= '0;
      cnt_q     <= '0;
      head_q    <= '0;
      k_q       <= '0;
      s1_q      <= 1'b0;
      s2_q      <= 1'b0;
      clr_q     <= '0;
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q <= st_d;
      s1_q <= (st_q == ST_PAIR);
      s2_q <= s1_q;
      if (cfg_we) begin
        cfg_q <= pwdata[CFG_W-1:0];
      end
      if (st_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (st_q == ST_PAIR) begin
        k_q <= k_q + 1'b1;
      end
      if (spread_upd) begin
        spread_q <= SPREAD_W'(pair_max);
      end
      if (accept) begin
        k_q <= '0;
        unique case (cmd)
          CMD_CLEAR: begin
            fill_q   <= '0;
            cnt_q    <= '0;
            spread_q <= md_eff;
            pend_q   <= 1'b1;
            clr_q    <= '0;
          end
          CMD_PUSH: begin
            head_q <= head_nxt;
            if (fill_q < DW'(MAX_DIST - 1)) begin
              fill_q <= fill_q + 1'b1;
            end
            if (cnt_q < CW'(MAX_LEN)) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          CMD_READ, CMD_NOP: ;
          default: ;
        endcase
      end
      if (load_out) begin
        pend_q    <= 1'b0;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    din1_q    <= k_q + 1'b1;
    hit2_q    <= hit;
    hw_addr_q <= {din1_q, DW'(dout)};
    if (st_q == ST_PAIR) begin
      rp_q <= rp_nxt;
    end
    if (st_q == ST_READ) begin
      res_cnt_q <= rng_q ? hist_rd_q : '0;
    end
    if (accept) begin
      v_q       <= in_val;
      md_q      <= md_eff;
      pairs_q   <= pairs_d;
      rp_q      <= head_prev;
      rng_q     <= in_range;
      res_cnt_q <= '0;
    end
    if (load_out) begin
      out_data_q <= {2'b00, COUNT_W'(cnt_q), spread_q, res_cnt_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (!s1_q && !s2_q))
    else $error("pair pipeline busy while idle");

  a_spread_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DRAIN) |-> (spread_q <= $past(spread_q)))
    else $error("spread rose during a push");

  a_no_row_zero_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_we && (st_q != ST_CLEAR)) |-> (hw_addr_q[HAW-1:DW] != '0))
    else $error("pair update hit input distance zero");

  a_done_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(st_q) == ST_DONE))
    else $error("result issued outside completion");

endmodule

// ===== sim/interleaver_spread_histogram_chk.sv =====
`timescale 1ns / 1ps
module interleaver_spread_histogram_chk import ish_pkg::*; #(
  parameter int unsigned MAX_DIST = 128,
  parameter int unsigned MAX_LEN  = 16384
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  // command[1:0], entry_value[15:2], bin_in_distance[22:16], bin_out_distance[29:23], zeros
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // bin_count[14:0], spread[22:15], entries_seen[37:23], zeros
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [31:0]            pwdata,
  input  logic [31:0]            prdata,
  input  logic                   pready,
  output int unsigned            pending_o,
  output int unsigned            errors_o
);

  typedef struct {
    logic [COUNT_W-1:0]  bin_count;
    logic [SPREAD_W-1:0] spread;
    logic [COUNT_W-1:0]  entries_seen;
  } bin_result_t;

  logic [COUNT_W-1:0] pair_hist [MAX_DIST][MAX_DIST];
  logic [VAL_W-1:0]   recent [MAX_DIST-1];
  int unsigned        recent_fill;
  int unsigned        spread_val;
  int unsigned        seen_cnt;
  logic [CFG_W-1:0]   max_dist_q;
  bin_result_t        due_results [$];

  function automatic int unsigned eff_dist();
    return (max_dist_q > MAX_DIST) ? MAX_DIST : max_dist_q;
  endfunction

  function automatic void wipe_all();
    for (int unsigned r = 0; r < MAX_DIST; r++) begin
      for (int unsigned c = 0; c < MAX_DIST; c++) begin
        pair_hist[r][c] = '0;
      end
    end
    recent_fill = 0;
    seen_cnt    = 0;
    spread_val  = eff_dist();
  endfunction

  function automatic void pair_new_entry(input logic [VAL_W-1:0] v);
    int unsigned md, pairs, din, dout, w, k;
    md    = eff_dist();
    pairs = (md > 1) ? md - 1 : 0;
    if (pairs > recent_fill) pairs = recent_fill;
    for (k = 0; k < pairs; k++) begin
      din  = k + 1;
      w    = recent[k];
      dout = (v >= w) ? v - w : w - v;
      if (dout < md && pair_hist[din][dout] != BIN_MAX) begin
        pair_hist[din][dout] = pair_hist[din][dout] + 1'b1;
      end
      if (din <= spread_val && dout <= spread_val) begin
        spread_val = (din > dout) ? din : dout;
      end
    end
    for (k = MAX_DIST - 2; k > 0; k--) begin
      recent[k] = recent[k-1];
    end
    recent[0] = v;
    if (recent_fill < MAX_DIST - 1) recent_fill++;
    if (seen_cnt < MAX_LEN) seen_cnt++;
  endfunction

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bin_result_t        got, want;
    logic [BIN_IDX_W-1:0] row, col;
    if (!rst_ni) begin
      max_dist_q = CFG_W'(MAX_DIST_RST);
      wipe_all();
      due_results.delete();
      pending_o = 0;
      errors_o  = 0;
    end else begin
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_MAX_DIST) begin
        if (pwrite) begin
          max_dist_q = pwdata[CFG_W-1:0];
        end else if (prdata != 32'(max_dist_q)) begin
          report("max_dist readback", prdata, max_dist_q);
        end
      end

      if (m_axis_tvalid && m_axis_tready) begin
        got.bin_count    = m_axis_tdata[COUNT_W-1:0];
        got.spread       = m_axis_tdata[COUNT_W +: SPREAD_W];
        got.entries_seen = m_axis_tdata[COUNT_W+SPREAD_W +: COUNT_W];
        if (due_results.size() == 0) begin
          report("result transfer with nothing due, bin_count", got.bin_count, 0);
        end else begin
          want = due_results.pop_front();
          if (got.bin_count != want.bin_count)
            report("bin_count", got.bin_count, want.bin_count);
          if (got.spread != want.spread)
            report("spread", got.spread, want.spread);
          if (got.entries_seen != want.entries_seen)
            report("entries_seen", got.entries_seen, want.entries_seen);
        end
      end

      if (s_axis_tvalid && s_axis_tready) begin
        want.bin_count = '0;
        row = s_axis_tdata[16 +: BIN_IDX_W];
        col = s_axis_tdata[16+BIN_IDX_W +: BIN_IDX_W];
        case (s_axis_tdata[CMD_W-1:0])
          CMD_CLEAR: wipe_all();
          CMD_PUSH:  pair_new_entry(s_axis_tdata[CMD_W +: VAL_W]);
          CMD_READ: begin
            if (row < MAX_DIST && col < MAX_DIST) want.bin_count = pair_hist[row][col];
          end
          default: ;
        endcase
        want.spread       = spread_val[SPREAD_W-1:0];
        want.entries_seen = seen_cnt[COUNT_W-1:0];
        due_results.push_back(want);
      end
      pending_o = due_results.size();
    end
  end

endmodule

// ===== sim/interleaver_spread_histogram_tb.sv =====
`timescale 1ns / 1ps
module interleaver_spread_histogram_tb;
  import ish_pkg::*;

  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 40;
  localparam int unsigned RUN_PUSHES  = 48;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;
  int unsigned            pending;
  int unsigned            mismatches;

  bit                     no_idle = 1'b0;
  int unsigned            rx_hold = 0;
  logic [CFG_W-1:0]       cur_md  = CFG_W'(MAX_DIST_RST);
  int                     last_val = 0;

  logic [CFG_W-1:0] phase_md  [N_PHASES] = '{8'd2, 8'd128, 8'd255, 8'd0, 8'd1, 8'd37, 8'd200,
                                             8'd100};
  bit               phase_clr [N_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  interleaver_spread_histogram u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  interleaver_spread_histogram_chk u_chk (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pending_o (pending),
    .errors_o  (mismatches)
  );

  task automatic send(input cmd_e cmd, input logic [VAL_W-1:0] val,
                      input logic [BIN_IDX_W-1:0] row, input logic [BIN_IDX_W-1:0] col);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, col, row, val, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({REG_MAX_DIST, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_max_dist(input logic [CFG_W-1:0] value);
    apb_xfer(1'b1, 32'(value));
    apb_xfer(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
    cur_md   = value;
  endtask

  task automatic random_item();
    int unsigned r, md, row, col;
    int          v;
    md = (cur_md > 128) ? 128 : cur_md;
    if (md < 2) md = 2;
    r = $urandom_range(0, 99);
    if (r == 0) begin
      send(CMD_CLEAR, VAL_W'($urandom), BIN_IDX_W'($urandom), BIN_IDX_W'($urandom));
    end else if (r < 6) begin
      send(CMD_NOP, VAL_W'($urandom), BIN_IDX_W'($urandom), BIN_IDX_W'($urandom));
    end else if (r < 36) begin
      if ($urandom_range(0, 2) != 0) begin
        row = $urandom_range(1, md - 1);
        col = $urandom_range(0, md - 1);
      end else begin
        row = $urandom_range(0, 127);
        col = $urandom_range(0, 127);
      end
      send(CMD_READ, VAL_W'($urandom), BIN_IDX_W'(row), BIN_IDX_W'(col));
    end else begin
      if ($urandom_range(0, 4) != 0) begin
        v = last_val + int'($urandom_range(0, 2 * md)) - int'(md);
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
      end else begin
        v = $urandom_range(0, 16383);
      end
      last_val = v;
      send(CMD_PUSH, VAL_W'(v), BIN_IDX_W'($urandom), BIN_IDX_W'($urandom));
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int unsigned stall;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (rx_hold != 0) begin
        stall  += rx_hold;
        rx_hold = 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    #6_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int unsigned      p, i;
    logic [VAL_W-1:0] run_val;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rst_ni        <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(CMD_NOP,  '1, '1, '1);
    send(CMD_READ, '0, 7'd0, 7'd0);
    send(CMD_READ, '0, 7'd127, 7'd127);
    send(CMD_PUSH, 14'd0, '0, '0);
    send(CMD_PUSH, 14'd16383, '0, '0);
    send(CMD_PUSH, 14'd16383, '0, '0);
    send(CMD_PUSH, 14'd0, '0, '0);
    send(CMD_PUSH, 14'd99, '0, '0);
    send(CMD_PUSH, 14'd199, '0, '0);
    send(CMD_PUSH, 14'd199, '0, '0);
    send(CMD_PUSH, 14'h2AAA, '0, '0);
    send(CMD_PUSH, 14'h1555, '0, '0);
    send(CMD_READ, '0, 7'd1, 7'd99);
    send(CMD_READ, '0, 7'd4, 7'd99);
    send(CMD_READ, '0, 7'd1, 7'd0);
    send(CMD_READ, '0, 7'd1, 7'd100);
    send(CMD_READ, '1, 7'h55, 7'h2A);
    send(CMD_READ, '0, 7'h2A, 7'h55);
    send(CMD_CLEAR, '1, '1, '1);
    send(CMD_READ, '0, 7'd1, 7'd0);
    send(CMD_PUSH, 14'd8191, '0, '0);
    send(CMD_NOP, '0, '0, '0);
    settle(8);

    for (p = 0; p < N_PHASES; p++) begin
      set_max_dist((p == N_PHASES - 1) ? CFG_W'($urandom_range(3, 127)) : phase_md[p]);
      no_idle = (p % 3 == 2);
      if (phase_clr[p]) send(CMD_CLEAR, '0, '0, '0);
      if (p == 1) rx_hold = 300;
      for (i = 0; i < PHASE_ITEMS; i++) random_item();
      settle(8);
    end

    // run of equal pushes at the smallest window: pile up bin (1,0)
    set_max_dist(8'd2);
    no_idle = 1'b1;
    run_val = VAL_W'($urandom);
    send(CMD_CLEAR, '0, '0, '0);
    for (i = 0; i < RUN_PUSHES; i++) send(CMD_PUSH, run_val, '0, '0);
    send(CMD_READ, '0, 7'd1, 7'd0);
    send(CMD_READ, '0, 7'd0, 7'd0);
    settle(16);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
